// ===== design/barsl_pkg.sv =====
package barsl_pkg;

    // identity length in bytes and derived sizes
    localparam int ID_BYTES  = 9;
    localparam int ID_W      = ID_BYTES * 8;
    localparam int SH_IDX_W  = $clog2(ID_BYTES);

    // address answered after reset
    localparam logic [7:0] ADDR_RESET = 8'd97;

    // input operations
    localparam logic [1:0] OP_WRITE_BYTE = 2'd0;
    localparam logic [1:0] OP_END_WRITE  = 2'd1;
    localparam logic [1:0] OP_READ_REQ   = 2'd2;
    localparam logic [1:0] OP_NONE       = 2'd3;

    // result kinds
    localparam logic KIND_READ   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // led events
    localparam logic [1:0] LED_NONE  = 2'd0;
    localparam logic [1:0] LED_GREEN = 2'd1;
    localparam logic [1:0] LED_RED   = 2'd2;
    localparam logic [1:0] LED_BLINK = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_ID_HIGH   = 3'd0;
    localparam logic [2:0] CFG_ID_SERIAL = 3'd1;
    localparam logic [2:0] CFG_ID_CAPS   = 3'd2;
    localparam logic [2:0] CFG_DEF_ADDR  = 3'd3;
    localparam logic [2:0] CFG_OP_ASSIGN = 3'd4;
    localparam logic [2:0] CFG_OP_PREP   = 3'd5;
    localparam logic [2:0] CFG_OP_GREEN  = 3'd6;
    localparam logic [2:0] CFG_OP_RED    = 3'd7;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] bus_byte;
    } req_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] read_byte;
        logic       last;
        logic       alert_low;
        logic       resolved;
        logic [7:0] bus_address;
        logic [1:0] led_event;
    } rsp_t;

    // identity shifter control and status
    typedef struct packed {
        logic load;
        logic shift;
    } sh_ctrl_t;

    typedef struct packed {
        logic [7:0]          data_byte;
        logic [SH_IDX_W-1:0] index;
        logic                last;
    } sh_stat_t;

endpackage

// ===== design/barsl_id_shifter.sv =====
module barsl_id_shifter
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  barsl_pkg::sh_ctrl_t           ctrl,
    input  logic [barsl_pkg::ID_W-1:0]    identity,
    output barsl_pkg::sh_stat_t           stat
);

    logic [barsl_pkg::ID_W-1:0]     data_reg;
    logic [barsl_pkg::ID_W-1:0]     data_next;
    logic [barsl_pkg::SH_IDX_W-1:0] idx_reg;
    logic [barsl_pkg::SH_IDX_W-1:0] idx_next;

    // load the identity, then move it out one byte per shift, msb first
    always_comb
    begin
        data_next = data_reg;
        idx_next  = idx_reg;
        if (ctrl.load)
        begin
            data_next = identity;
            idx_next  = '0;
        end
        else if (ctrl.shift)
        begin
            data_next = {data_reg[barsl_pkg::ID_W-9:0], 8'd0};
            idx_next  = idx_reg + barsl_pkg::SH_IDX_W'(1);
        end
    end

    // byte position counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    // shift register payload
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign stat.data_byte = data_reg[barsl_pkg::ID_W-1 -: 8];
    assign stat.index     = idx_reg;
    assign stat.last      = (idx_reg == barsl_pkg::SH_IDX_W'(barsl_pkg::ID_BYTES - 1));

endmodule

// ===== design/bus_address_resolution_slave.sv =====
// Target side of a simplified bus address-resolution protocol.
// Request channel (req_valid / req_stall / req_data) carries one bus event per
// transfer: a received write byte, the end of a write, a read request or none.
// Response channel (rsp_valid / rsp_stall / rsp_data) returns read data bytes
// and command status; each transfer carries the current alert, resolved and
// address state. The config channel (cfg_valid / cfg_ready) writes the identity
// and opcode registers; cfg_ready is always high, write only while idle.
// A write byte gives no response. An end of write returns one status result
// from the emit state, after the compare state for an assign command that is
// compared, where the identity shifter checks one byte per cycle against the
// receive buffer. A read request returns one byte when resolved, or else the
// shifter sends one identity byte per cycle unless rsp_stall holds a result.
// The response register holds one result; while rsp_stall is high the block
// waits with that result and with any further result. A new request is taken
// once the last result of the current one is in the response register, so it
// can be accepted while that result still waits under rsp_stall.
// Reset clears the buffer count, resolved flag, asserts alert, restores the
// assigned address to 97 and the registers to their reset values.
module bus_address_resolution_slave
#(
    parameter int RECEIVE_DEPTH = 12
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  barsl_pkg::req_t     req_data,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output barsl_pkg::rsp_t     rsp_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    localparam int CNT_W = $clog2(RECEIVE_DEPTH + 1);
    localparam int IDX_W = $clog2(RECEIVE_DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;
    localparam logic [1:0] ST_READ = 2'd3;

    // configuration registers
    logic [31:0] id_high_reg;
    logic [31:0] id_serial_reg;
    logic [7:0]  id_caps_reg;
    logic [6:0]  def_addr_reg;
    logic [7:0]  op_assign_reg;
    logic [7:0]  op_prep_reg;
    logic [7:0]  op_green_reg;
    logic [7:0]  op_red_reg;

    // block state
    logic [1:0]       state_reg,    state_next;
    logic [CNT_W-1:0] count_reg,    count_next;
    logic             resolved_reg, resolved_next;
    logic [7:0]       assigned_reg, assigned_next;
    logic             alert_reg,    alert_next;
    logic             mism_reg,     mism_next;
    logic             rsp_valid_reg, rsp_valid_next;
    barsl_pkg::rsp_t  rsp_data_reg, rsp_data_next;
    logic             pend_kind_reg, pend_kind_next;
    logic [7:0]       pend_byte_reg, pend_byte_next;
    logic [1:0]       pend_led_reg,  pend_led_next;
    logic [7:0]       buf_reg [RECEIVE_DEPTH];

    logic                 req_fire;
    logic                 rsp_free;
    logic                 buf_we;
    logic [7:0]           cmd_byte;
    logic [IDX_W-1:0]     cmp_ptr;
    logic                 cur_mism;
    logic [7:0]           cur_addr;
    barsl_pkg::sh_ctrl_t  sh_ctrl;
    barsl_pkg::sh_stat_t  sh_stat;

    assign cfg_ready = 1'b1;
    assign req_stall = (state_reg != ST_IDLE);
    assign req_fire  = req_valid && !req_stall;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    assign cmd_byte = buf_reg[0];
    assign cmp_ptr  = IDX_W'(sh_stat.index) + IDX_W'(1);
    assign cur_mism = mism_reg || (buf_reg[cmp_ptr] != sh_stat.data_byte);
    assign cur_addr = resolved_reg ? assigned_reg : {1'b0, def_addr_reg};
    assign buf_we   = req_fire && (req_data.operation == barsl_pkg::OP_WRITE_BYTE)
                      && (count_reg < CNT_W'(RECEIVE_DEPTH));

    barsl_id_shifter u_id_shifter
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (sh_ctrl),
        .identity ({id_high_reg, id_serial_reg, id_caps_reg}),
        .stat     (sh_stat)
    );

    // command sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        resolved_next  = resolved_reg;
        assigned_next  = assigned_reg;
        alert_next     = alert_reg;
        mism_next      = mism_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        pend_kind_next = pend_kind_reg;
        pend_byte_next = pend_byte_reg;
        pend_led_next  = pend_led_reg;
        sh_ctrl.load   = 1'b0;
        sh_ctrl.shift  = 1'b0;

        // response transfer frees the output register
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    unique case (req_data.operation)
                        barsl_pkg::OP_WRITE_BYTE:
                        begin
                            if (count_reg < CNT_W'(RECEIVE_DEPTH))
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        barsl_pkg::OP_END_WRITE:
                        begin
                            count_next     = '0;
                            pend_kind_next = barsl_pkg::KIND_STATUS;
                            pend_byte_next = 8'd0;
                            pend_led_next  = barsl_pkg::LED_NONE;
                            state_next     = ST_EMIT;
                            // first matching opcode wins
                            if (count_reg != '0)
                            begin
                                priority if (cmd_byte == op_assign_reg)
                                begin
                                    if (count_reg >= CNT_W'(barsl_pkg::ID_BYTES + 2)
                                        && !resolved_reg)
                                    begin
                                        sh_ctrl.load = 1'b1;
                                        mism_next    = 1'b0;
                                        state_next   = ST_CMP;
                                    end
                                end
                                else if (cmd_byte == op_prep_reg)
                                begin
                                    resolved_next = 1'b0;
                                end
                                else if (cmd_byte == op_green_reg)
                                begin
                                    pend_led_next = barsl_pkg::LED_GREEN;
                                end
                                else if (cmd_byte == op_red_reg)
                                begin
                                    pend_led_next = barsl_pkg::LED_RED;
                                end
                                else
                                begin
                                    pend_led_next = barsl_pkg::LED_NONE;
                                end
                            end
                        end
                        barsl_pkg::OP_READ_REQ:
                        begin
                            if (resolved_reg)
                            begin
                                pend_kind_next = barsl_pkg::KIND_READ;
                                pend_byte_next = assigned_reg;
                                pend_led_next  = barsl_pkg::LED_NONE;
                                state_next     = ST_EMIT;
                            end
                            else
                            begin
                                sh_ctrl.load = 1'b1;
                                state_next   = ST_READ;
                            end
                        end
                        barsl_pkg::OP_NONE:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CMP:
            begin
                // one identity byte compared per cycle
                sh_ctrl.shift = 1'b1;
                mism_next     = cur_mism;
                if (sh_stat.last)
                begin
                    state_next = ST_EMIT;
                    if (!cur_mism)
                    begin
                        assigned_next = buf_reg[IDX_W'(barsl_pkg::ID_BYTES + 1)];
                        resolved_next = 1'b1;
                        alert_next    = 1'b0;
                        pend_led_next = barsl_pkg::LED_BLINK;
                    end
                    else
                    begin
                        alert_next = 1'b1;
                    end
                end
            end
            ST_EMIT:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next            = 1'b1;
                    rsp_data_next.kind        = pend_kind_reg;
                    rsp_data_next.read_byte   = pend_byte_reg;
                    rsp_data_next.last        = 1'b1;
                    rsp_data_next.alert_low   = alert_reg;
                    rsp_data_next.resolved    = resolved_reg;
                    rsp_data_next.bus_address = cur_addr;
                    rsp_data_next.led_event   = pend_led_reg;
                    state_next                = ST_IDLE;
                end
            end
            ST_READ:
            begin
                // one identity byte sent per response transfer
                if (rsp_free)
                begin
                    sh_ctrl.shift             = 1'b1;
                    rsp_valid_next            = 1'b1;
                    rsp_data_next.kind        = barsl_pkg::KIND_READ;
                    rsp_data_next.read_byte   = sh_stat.data_byte;
                    rsp_data_next.last        = sh_stat.last;
                    rsp_data_next.alert_low   = alert_reg;
                    rsp_data_next.resolved    = resolved_reg;
                    rsp_data_next.bus_address = cur_addr;
                    rsp_data_next.led_event   = barsl_pkg::LED_NONE;
                    if (sh_stat.last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            resolved_reg  <= 1'b0;
            assigned_reg  <= barsl_pkg::ADDR_RESET;
            alert_reg     <= 1'b1;
            mism_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            resolved_reg  <= resolved_next;
            assigned_reg  <= assigned_next;
            alert_reg     <= alert_next;
            mism_reg      <= mism_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_high_reg   <= 32'd0;
            id_serial_reg <= 32'd0;
            id_caps_reg   <= 8'd0;
            def_addr_reg  <= barsl_pkg::ADDR_RESET[6:0];
            op_assign_reg <= 8'd4;
            op_prep_reg   <= 8'd1;
            op_green_reg  <= 8'd16;
            op_red_reg    <= 8'd17;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                barsl_pkg::CFG_ID_HIGH:   id_high_reg   <= cfg_data;
                barsl_pkg::CFG_ID_SERIAL: id_serial_reg <= cfg_data;
                barsl_pkg::CFG_ID_CAPS:   id_caps_reg   <= cfg_data[7:0];
                barsl_pkg::CFG_DEF_ADDR:  def_addr_reg  <= cfg_data[6:0];
                barsl_pkg::CFG_OP_ASSIGN: op_assign_reg <= cfg_data[7:0];
                barsl_pkg::CFG_OP_PREP:   op_prep_reg   <= cfg_data[7:0];
                barsl_pkg::CFG_OP_GREEN:  op_green_reg  <= cfg_data[7:0];
                barsl_pkg::CFG_OP_RED:    op_red_reg    <= cfg_data[7:0];
            endcase
        end
    end

    // payload registers and receive buffer
    always_ff @(posedge clk)
    begin
        rsp_data_reg  <= rsp_data_next;
        pend_kind_reg <= pend_kind_next;
        pend_byte_reg <= pend_byte_next;
        pend_led_reg  <= pend_led_next;
        if (buf_we)
        begin
            buf_reg[count_reg[IDX_W-1:0]] <= req_data.bus_byte;
        end
    end

    // receive count never passes the buffer depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(RECEIVE_DEPTH))
        else $error("receive count beyond buffer depth");

    // a successful assignment always releases alert
    a_resolve_alert: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(resolved_reg) |-> !alert_reg)
        else $error("resolved without releasing alert");

    // a status result is always the single and final result
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_data_reg.kind == barsl_pkg::KIND_STATUS)
        |-> rsp_data_reg.last)
        else $error("status result without last");

    // compare pass ends in the emit state
    a_cmp_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP && sh_stat.last) |=> (state_reg == ST_EMIT))
        else $error("compare pass did not end in emit");

    // the shifter never runs past the identity while sending or comparing
    a_read_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ || state_reg == ST_CMP)
        |-> (sh_stat.index <= barsl_pkg::SH_IDX_W'(barsl_pkg::ID_BYTES - 1)))
        else $error("identity index out of range");

endmodule

// ===== tb/sv/bus_address_resolution_slave_checker.sv =====
`timescale 1ns / 1ps

module bus_address_resolution_slave_checker
#(
    parameter int RECEIVE_DEPTH = 12
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_stall,
    input  barsl_pkg::req_t     req_data,
    input  logic                rsp_valid,
    input  logic                rsp_stall,
    input  barsl_pkg::rsp_t     rsp_data,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output int                  fail_count,
    output int                  pending_count,
    output int                  checked_count
);

    // register image
    logic [31:0] id_high_q;
    logic [31:0] id_serial_q;
    logic [7:0]  id_caps_q;
    logic [6:0]  def_addr_q;
    logic [7:0]  op_assign_q;
    logic [7:0]  op_prep_q;
    logic [7:0]  op_green_q;
    logic [7:0]  op_red_q;

    // target state
    logic [7:0]  rx_bytes [RECEIVE_DEPTH];
    int          rx_count;
    logic        resolved_q;
    logic [7:0]  assigned_q;
    logic        alert_q;

    // responses the block still owes, oldest first
    barsl_pkg::rsp_t awaited_responses [$];

    // identity byte i, big endian within each register
    function automatic logic [7:0] identity_byte(input int i);
        if (i < 4)
            return id_high_q[31 - 8 * i -: 8];
        else if (i < 8)
            return id_serial_q[31 - 8 * (i - 4) -: 8];
        else
            return id_caps_q;
    endfunction

    // response word carrying the current alert, resolved and address state
    function automatic barsl_pkg::rsp_t state_response(input logic kind,
                                                       input logic [7:0] data,
                                                       input logic last,
                                                       input logic [1:0] led);
        barsl_pkg::rsp_t r;
        r.kind        = kind;
        r.read_byte   = data;
        r.last        = last;
        r.alert_low   = alert_q;
        r.resolved    = resolved_q;
        r.bus_address = resolved_q ? assigned_q : {1'b0, def_addr_q};
        r.led_event   = led;
        return r;
    endfunction

    // command decode at the end of a write, first matching opcode wins
    task automatic decode_command(output logic [1:0] led);
        logic same_id;
        int   i;
        led     = barsl_pkg::LED_NONE;
        same_id = 1'b1;
        if (rx_count != 0)
        begin
            if (rx_bytes[0] == op_assign_q)
            begin
                // short frames and assigns after resolution are ignored
                if (rx_count >= barsl_pkg::ID_BYTES + 2 && !resolved_q)
                begin
                    for (i = 0; i < barsl_pkg::ID_BYTES; i++)
                        if (rx_bytes[i + 1] != identity_byte(i))
                            same_id = 1'b0;
                    if (same_id)
                    begin
                        assigned_q = rx_bytes[barsl_pkg::ID_BYTES + 1];
                        resolved_q = 1'b1;
                        alert_q    = 1'b0;
                        led        = barsl_pkg::LED_BLINK;
                    end
                    else
                    begin
                        alert_q = 1'b1;
                    end
                end
            end
            else if (rx_bytes[0] == op_prep_q)
                resolved_q = 1'b0;
            else if (rx_bytes[0] == op_green_q)
                led = barsl_pkg::LED_GREEN;
            else if (rx_bytes[0] == op_red_q)
                led = barsl_pkg::LED_RED;
        end
    endtask

    // advance the state by one accepted bus event and queue its responses
    task automatic follow_bus_event(input barsl_pkg::req_t ev);
        logic [1:0] led;
        int         i;
        case (ev.operation)
            barsl_pkg::OP_WRITE_BYTE:
            begin
                if (rx_count < RECEIVE_DEPTH)
                begin
                    rx_bytes[rx_count] = ev.bus_byte;
                    rx_count++;
                end
            end
            barsl_pkg::OP_END_WRITE:
            begin
                decode_command(led);
                rx_count = 0;
                awaited_responses.push_back(
                    state_response(barsl_pkg::KIND_STATUS, 8'h00, 1'b1, led));
            end
            barsl_pkg::OP_READ_REQ:
            begin
                if (resolved_q)
                    awaited_responses.push_back(state_response(barsl_pkg::KIND_READ,
                        assigned_q, 1'b1, barsl_pkg::LED_NONE));
                else
                    for (i = 0; i < barsl_pkg::ID_BYTES; i++)
                        awaited_responses.push_back(state_response(barsl_pkg::KIND_READ,
                            identity_byte(i), i == barsl_pkg::ID_BYTES - 1,
                            barsl_pkg::LED_NONE));
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            fail_count++;
            $display("%0t: response %0d field %s expected %0h actual %0h",
                     $time, checked_count, name, want, got);
        end
    endtask

    // compare one response transfer against the oldest awaited one
    task automatic compare_response(input barsl_pkg::rsp_t got);
        barsl_pkg::rsp_t want;
        if (awaited_responses.size() == 0)
        begin
            fail_count++;
            $display("%0t: response expected none actual %0h", $time, got);
        end
        else
        begin
            want = awaited_responses.pop_front();
            check_field("kind", 8'(want.kind), 8'(got.kind));
            check_field("read_byte", want.read_byte, got.read_byte);
            check_field("last", 8'(want.last), 8'(got.last));
            check_field("alert_low", 8'(want.alert_low), 8'(got.alert_low));
            check_field("resolved", 8'(want.resolved), 8'(got.resolved));
            check_field("bus_address", want.bus_address, got.bus_address);
            check_field("led_event", 8'(want.led_event), 8'(got.led_event));
            checked_count++;
        end
    endtask

    // watch all three channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_high_q     = '0;
            id_serial_q   = '0;
            id_caps_q     = '0;
            def_addr_q    = barsl_pkg::ADDR_RESET[6:0];
            op_assign_q   = 8'd4;
            op_prep_q     = 8'd1;
            op_green_q    = 8'd16;
            op_red_q      = 8'd17;
            rx_count      = 0;
            resolved_q    = 1'b0;
            assigned_q    = barsl_pkg::ADDR_RESET;
            alert_q       = 1'b1;
            awaited_responses.delete();
            fail_count    = 0;
            checked_count = 0;
            pending_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    barsl_pkg::CFG_ID_HIGH:   id_high_q   = cfg_data;
                    barsl_pkg::CFG_ID_SERIAL: id_serial_q = cfg_data;
                    barsl_pkg::CFG_ID_CAPS:   id_caps_q   = cfg_data[7:0];
                    barsl_pkg::CFG_DEF_ADDR:  def_addr_q  = cfg_data[6:0];
                    barsl_pkg::CFG_OP_ASSIGN: op_assign_q = cfg_data[7:0];
                    barsl_pkg::CFG_OP_PREP:   op_prep_q   = cfg_data[7:0];
                    barsl_pkg::CFG_OP_GREEN:  op_green_q  = cfg_data[7:0];
                    barsl_pkg::CFG_OP_RED:    op_red_q    = cfg_data[7:0];
                    default:
                    begin
                    end
                endcase
            end
            if (rsp_valid && !rsp_stall)
                compare_response(rsp_data);
            if (req_valid && !req_stall)
                follow_bus_event(req_data);
            pending_count = awaited_responses.size();
        end
    end

endmodule

// ===== tb/sv/bus_address_resolution_slave_tb.sv =====
`timescale 1ns / 1ps

module bus_address_resolution_slave_tb;

    localparam int RECEIVE_DEPTH = 12;
    // slowest run is roughly 500 events of nine responses behind long stalls
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int QUIET_CYCLES  = 12;
    localparam int PHASE_EVENTS  = 86;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            req_valid;
    logic            req_stall;
    barsl_pkg::req_t req_data;
    logic            rsp_valid;
    logic            rsp_stall;
    barsl_pkg::rsp_t rsp_data;
    logic            cfg_valid;
    logic            cfg_ready;
    logic [2:0]      cfg_index;
    logic [31:0]     cfg_data;

    int          fail_count;
    int          pending_count;
    int          checked_count;

    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          bus_events = 0;
    int          settings_used = 1;
    int          cycle_count = 0;
    logic [31:0] cfg_image [8];

    always #6 clk = ~clk;

    bus_address_resolution_slave #(.RECEIVE_DEPTH(RECEIVE_DEPTH)) i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bus_address_resolution_slave_checker #(.RECEIVE_DEPTH(RECEIVE_DEPTH)) i_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req_data      (req_data),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .rsp_data      (rsp_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .checked_count (checked_count)
    );

    // random backpressure on the response side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // hang guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, pending_count);
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [7:0] identity_at(input int i);
        if (i < 4)
            return cfg_image[barsl_pkg::CFG_ID_HIGH][31 - 8 * i -: 8];
        else if (i < 8)
            return cfg_image[barsl_pkg::CFG_ID_SERIAL][31 - 8 * (i - 4) -: 8];
        else
            return cfg_image[barsl_pkg::CFG_ID_CAPS][7:0];
    endfunction

    // random bits above the register width, the block must drop them
    function automatic logic [31:0] with_noise(input logic [31:0] value,
                                               input logic [31:0] keep);
        return (value & keep) | ($urandom & ~keep);
    endfunction

    // one request transfer, with an optional random gap in front
    task automatic send_event(input logic [1:0] op, input logic [7:0] value);
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        req_valid <= 1'b1;
        req_data  <= {op, value};
        do @(posedge clk); while (req_stall);
        bus_events++;
    endtask

    // bytes of one bus write followed by its end
    task automatic send_frame(input logic [7:0] frame [$]);
        foreach (frame[i])
            send_event(barsl_pkg::OP_WRITE_BYTE, frame[i]);
        send_event(barsl_pkg::OP_END_WRITE, 8'($urandom_range(0, 255)));
    endtask

    // hold off until every response is in and the block has settled
    task automatic wait_quiet();
        req_valid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0)
            @(negedge clk);
        @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
        cfg_valid      <= 1'b1;
        cfg_index      <= idx;
        cfg_data       <= value;
        cfg_image[idx]  = value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // register settings for each random phase
    task automatic load_setting(input int setting);
        logic [31:0] id_high;
        logic [31:0] id_serial;
        logic [7:0]  caps;
        logic [6:0]  def_addr;
        logic [7:0]  op_assign;
        logic [7:0]  op_prep;
        logic [7:0]  op_green;
        logic [7:0]  op_red;
        id_high   = $urandom;
        id_serial = $urandom;
        caps      = 8'($urandom_range(0, 255));
        def_addr  = 7'($urandom_range(0, 127));
        op_assign = 8'd4;
        op_prep   = 8'd1;
        op_green  = 8'd16;
        op_red    = 8'd17;
        case (setting)
            1:
            begin
                def_addr = 7'd0;
            end
            2:
            begin
                id_high   = 32'hFFFF_FFFF;
                id_serial = 32'hFFFF_FFFF;
                caps      = 8'hFF;
                def_addr  = 7'd127;
                op_assign = 8'hFF;
                op_prep   = 8'h00;
                op_green  = 8'h80;
                op_red    = 8'h7F;
            end
            3:
            begin
                op_assign = 8'($urandom_range(0, 255));
                op_prep   = 8'($urandom_range(0, 255));
                op_green  = 8'($urandom_range(0, 255));
                op_red    = 8'($urandom_range(0, 255));
            end
            4:
            begin
                // assign shadows prepare, green shadows red
                op_assign = 8'($urandom_range(0, 255));
                op_prep   = op_assign;
                op_green  = op_assign ^ 8'h5A;
                op_red    = op_green;
            end
            default:
            begin
                // prepare shadows both led commands
                op_assign = 8'h00;
                op_prep   = 8'h22;
                op_green  = 8'h22;
                op_red    = 8'h22;
            end
        endcase
        write_register(barsl_pkg::CFG_ID_HIGH, id_high);
        write_register(barsl_pkg::CFG_ID_SERIAL, id_serial);
        write_register(barsl_pkg::CFG_ID_CAPS, with_noise(32'(caps), 32'hFF));
        write_register(barsl_pkg::CFG_DEF_ADDR, with_noise(32'(def_addr), 32'h7F));
        write_register(barsl_pkg::CFG_OP_ASSIGN, with_noise(32'(op_assign), 32'hFF));
        write_register(barsl_pkg::CFG_OP_PREP, with_noise(32'(op_prep), 32'hFF));
        write_register(barsl_pkg::CFG_OP_GREEN, with_noise(32'(op_green), 32'hFF));
        write_register(barsl_pkg::CFG_OP_RED, with_noise(32'(op_red), 32'hFF));
        cfg_valid <= 1'b0;
    endtask

    // extremes of the fields and one of each command at reset settings
    task automatic run_directed();
        logic [7:0] frame [$];
        int         i;
        send_event(barsl_pkg::OP_READ_REQ, 8'h00);
        send_event(barsl_pkg::OP_END_WRITE, 8'hFF);
        send_event(barsl_pkg::OP_NONE, 8'hA5);
        frame.delete();
        frame.push_back(cfg_image[barsl_pkg::CFG_OP_GREEN][7:0]);
        send_frame(frame);
        frame.delete();
        frame.push_back(cfg_image[barsl_pkg::CFG_OP_RED][7:0]);
        send_frame(frame);
        // matching assign with the highest address byte
        frame.delete();
        frame.push_back(cfg_image[barsl_pkg::CFG_OP_ASSIGN][7:0]);
        for (i = 0; i < barsl_pkg::ID_BYTES; i++)
            frame.push_back(identity_at(i));
        frame.push_back(8'hFF);
        send_frame(frame);
        send_event(barsl_pkg::OP_READ_REQ, 8'h5A);
        frame.delete();
        frame.push_back(cfg_image[barsl_pkg::CFG_OP_PREP][7:0]);
        send_frame(frame);
        send_event(barsl_pkg::OP_READ_REQ, 8'h00);
    endtask

    // mostly well-formed commands with random content, some noise
    task automatic send_random_frame();
        logic [7:0] frame [$];
        int         pick;
        int         keep;
        int         pos;
        int         i;
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            frame.push_back(cfg_image[barsl_pkg::CFG_OP_ASSIGN][7:0]);
            for (i = 0; i < barsl_pkg::ID_BYTES; i++)
                frame.push_back(identity_at(i));
            frame.push_back(8'($urandom_range(0, 255)));
            if (pick >= 30 && pick < 40)
            begin
                // identity mismatch
                pos = $urandom_range(1, barsl_pkg::ID_BYTES);
                frame[pos] = frame[pos] ^ 8'($urandom_range(1, 255));
            end
            else if (pick >= 40)
            begin
                // frame too short to assign
                keep = $urandom_range(1, barsl_pkg::ID_BYTES + 1);
                while (frame.size() > keep)
                    void'(frame.pop_back());
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                // trailing bytes, some past the buffer depth
                repeat ($urandom_range(1, 4))
                    frame.push_back(8'($urandom_range(0, 255)));
            end
            send_frame(frame);
        end
        else if (pick < 73)
        begin
            if (pick < 57)
                frame.push_back(cfg_image[barsl_pkg::CFG_OP_PREP][7:0]);
            else if (pick < 65)
                frame.push_back(cfg_image[barsl_pkg::CFG_OP_GREEN][7:0]);
            else
                frame.push_back(cfg_image[barsl_pkg::CFG_OP_RED][7:0]);
            repeat ($urandom_range(0, 2))
                frame.push_back(8'($urandom_range(0, 255)));
            send_frame(frame);
        end
        else if (pick < 80)
        begin
            // arbitrary write, possibly empty
            repeat ($urandom_range(0, 14))
                frame.push_back(8'($urandom_range(0, 255)));
            send_frame(frame);
        end
        else if (pick < 96)
            send_event(barsl_pkg::OP_READ_REQ, 8'($urandom_range(0, 255)));
        else
            send_event(barsl_pkg::OP_NONE, 8'($urandom_range(0, 255)));
    endtask

    // stimulus and verdict
    initial
    begin
        int setting;
        int phase_start;
        req_valid <= 1'b0;
        req_data  <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= barsl_pkg::CFG_ID_HIGH;
        cfg_data  <= '0;
        cfg_image[barsl_pkg::CFG_ID_HIGH]   = 32'd0;
        cfg_image[barsl_pkg::CFG_ID_SERIAL] = 32'd0;
        cfg_image[barsl_pkg::CFG_ID_CAPS]   = 32'd0;
        cfg_image[barsl_pkg::CFG_DEF_ADDR]  = 32'(barsl_pkg::ADDR_RESET);
        cfg_image[barsl_pkg::CFG_OP_ASSIGN] = 32'd4;
        cfg_image[barsl_pkg::CFG_OP_PREP]   = 32'd1;
        cfg_image[barsl_pkg::CFG_OP_GREEN]  = 32'd16;
        cfg_image[barsl_pkg::CFG_OP_RED]    = 32'd17;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        for (setting = 1; setting <= 5; setting++)
        begin
            wait_quiet();
            load_setting(setting);
            settings_used++;
            case (setting)
                1:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 76;
                    stall_pct     = 0;
                end
                3:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 76;
                end
                4:
                begin
                    send_idle_pct = 18;
                    stall_pct     = 18;
                end
                default:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
            endcase
            phase_start = bus_events;
            while (bus_events - phase_start < PHASE_EVENTS)
                send_random_frame();
        end

        wait_quiet();
        repeat (QUIET_CYCLES) @(posedge clk);
        $display("%0d bus events sent, %0d responses checked", bus_events, checked_count);
        $display("%0d register settings, idle and stall mixes of 0, 18 and 76 percent",
                 settings_used);
        if (fail_count == 0 && pending_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/barsl_pkg.sv
design/barsl_id_shifter.sv
design/bus_address_resolution_slave.sv
tb/sv/bus_address_resolution_slave_checker.sv
tb/sv/bus_address_resolution_slave_tb.sv
